### rtl/tcpu_pkg.sv
// Shared constants and codes for the text cursor position unit.
package tcpu_pkg;

	// Screen geometry bounds
	localparam int unsigned MAX_ROWS = 64;
	localparam int unsigned MAX_COLS = 128;

	// Register reset values
	localparam logic [6:0] ROW_COUNT_RST       = 7'd25;
	localparam logic [7:0] COLUMN_COUNT_RST    = 8'd80;
	localparam logic [4:0] BLOCK_LAST_SCAN_RST = 5'd15;

	// Configuration register indexes
	localparam logic [1:0] REG_ROW_COUNT       = 2'd0;
	localparam logic [1:0] REG_COLUMN_COUNT    = 2'd1;
	localparam logic [1:0] REG_BLOCK_LAST_SCAN = 2'd2;

	// Command codes
	typedef enum logic [3:0] {
		FUNC_SET_XY      = 4'd0,
		FUNC_LINE_START  = 4'd1,
		FUNC_UP          = 4'd2,
		FUNC_DOWN        = 4'd3,
		FUNC_LEFT        = 4'd4,
		FUNC_RIGHT       = 4'd5,
		FUNC_SET_TYPE    = 4'd6,
		FUNC_TO_OFFSET   = 4'd7,
		FUNC_FROM_OFFSET = 4'd8
	} func_t;

	// Cursor shape codes
	localparam logic [1:0] SHAPE_BLOCK     = 2'd0;
	localparam logic [1:0] SHAPE_UNDERLINE = 2'd1;
	localparam logic [1:0] SHAPE_THICK     = 2'd2;
	localparam logic [1:0] SHAPE_INVALID   = 2'd3;

	// Step counts of the shared adder
	localparam logic [3:0] MUL_LAST_STEP = 4'd6;
	localparam logic [3:0] DIV_LAST_STEP = 4'd12;

endpackage

### rtl/text_cursor_position_unit.sv
// Text cursor position unit: cursor state, moves and offset conversions.
//
// Every command word gives one result word. Position moves, set_xy, set_type
// and rejected commands go from acceptance straight to the result state. A
// to_offset with an in-range row and column first passes through ST_MUL: one
// shared adder forms row * columns + column by shift-and-add over the six row
// bits and a final column add. A from_offset passes through ST_DIV, where the
// same adder runs a restoring division of the 13-bit offset by the column
// count, one quotient bit a cycle. The unit holds one command at a time; in_ready is
// low from acceptance until the result word is loaded into the output
// register, which may then wait for out_ready while the next command is taken.
// Configuration writes are always accepted and take effect at once.
module text_cursor_position_unit
	import tcpu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// command channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  func,
	input  logic [5:0]  req_row,
	input  logic [6:0]  req_col,
	input  logic        allow_scroll,
	input  logic [1:0]  req_type,
	input  logic [12:0] req_offset,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic        scroll,
	output logic [5:0]  out_row,
	output logic [6:0]  out_col,
	output logic [12:0] out_offset,
	output logic [1:0]  shape,
	output logic [4:0]  first_scan,
	output logic [4:0]  last_scan
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t      state_q;
	logic [3:0]  cnt_q;
	logic [12:0] acc_q;
	logic [6:0]  rem_q;
	logic [5:0]  mrow_q;

	func_t       func_q;
	logic [5:0]  req_row_q;
	logic [6:0]  req_col_q;
	logic        allow_q;
	logic [1:0]  req_type_q;

	logic [6:0]  row_count_q;
	logic [7:0]  column_count_q;
	logic [4:0]  block_last_scan_q;

	logic [5:0]  cursor_row_q;
	logic [6:0]  cursor_col_q;
	logic [1:0]  cursor_shape_q;

	logic        out_valid_q;
	logic        ok_q;
	logic        scroll_q;
	logic [5:0]  out_row_q;
	logic [6:0]  out_col_q;
	logic [12:0] out_offset_q;
	logic [1:0]  shape_q;
	logic [4:0]  last_scan_q;

	logic [6:0]  rows;
	logic [7:0]  cols;
	logic        in_acc;
	logic        out_free;
	logic        req_in_range;

	// Clamp the geometry to the supported screen
	always_comb begin
		rows = row_count_q;
		if (row_count_q == 7'd0) begin
			rows = 7'd1;
		end else if ({25'd0, row_count_q} > MAX_ROWS) begin
			rows = 7'(MAX_ROWS);
		end
		cols = column_count_q;
		if (column_count_q == 8'd0) begin
			cols = 8'd1;
		end else if ({24'd0, column_count_q} > MAX_COLS) begin
			cols = 8'(MAX_COLS);
		end
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign req_in_range = ({1'b0, req_row} < rows) && ({1'b0, req_col} < cols);

	// Shared adder: shift-and-add for to_offset, trial subtract for from_offset
	logic [12:0] alu_a;
	logic [12:0] alu_b;
	logic        alu_sub;
	logic [13:0] alu_sum;
	logic        div_fits;
	logic [6:0]  div_rem;

	always_comb begin
		alu_a   = {acc_q[11:0], 1'b0};
		alu_b   = mrow_q[5] ? {5'd0, cols} : 13'd0;
		alu_sub = 1'b0;
		if (state_q == ST_DIV) begin
			alu_a   = {5'd0, rem_q, acc_q[12]};
			alu_b   = {5'd0, cols};
			alu_sub = 1'b1;
		end else if (cnt_q == MUL_LAST_STEP) begin
			alu_a = acc_q;
			alu_b = {6'd0, req_col_q};
		end
		alu_sum = {1'b0, alu_a} + (alu_sub ? ~{1'b0, alu_b} : {1'b0, alu_b})
			+ {13'd0, alu_sub};
		div_fits = !alu_sum[13];
		div_rem  = div_fits ? alu_sum[6:0] : {rem_q[5:0], acc_q[12]};
	end

	// Work out the result word and the next cursor state
	logic        f_ok;
	logic        f_scroll;
	logic [5:0]  f_row;
	logic [6:0]  f_col;
	logic [12:0] f_offset;
	logic [1:0]  f_shape;
	logic [5:0]  n_row;
	logic [6:0]  n_col;
	logic        pos_valid;
	logic        at_top;
	logic        at_bottom;
	logic        q_over;

	always_comb begin
		pos_valid = ({1'b0, cursor_row_q} < rows) && ({1'b0, cursor_col_q} < cols);
		at_top    = (cursor_row_q == 6'd0);
		at_bottom = ({1'b0, cursor_row_q} + 7'd1 >= rows);
		q_over    = (acc_q >= {6'd0, rows});
		f_ok      = 1'b0;
		f_scroll  = 1'b0;
		f_offset  = 13'd0;
		f_shape   = cursor_shape_q;
		n_row     = cursor_row_q;
		n_col     = cursor_col_q;
		f_row     = 6'd0;
		f_col     = 7'd0;
		unique case (func_q)
			FUNC_SET_XY: begin
				if (({1'b0, req_row_q} < rows) && ({1'b0, req_col_q} < cols)) begin
					n_row = req_row_q;
					n_col = req_col_q;
					f_ok  = 1'b1;
				end
			end
			FUNC_LINE_START: begin
				if (pos_valid) begin
					n_col = 7'd0;
					f_ok  = 1'b1;
				end
			end
			FUNC_UP: begin
				if (pos_valid) begin
					f_ok = 1'b1;
					if (at_top) f_scroll = allow_q;
					else n_row = cursor_row_q - 6'd1;
				end
			end
			FUNC_DOWN: begin
				if (pos_valid) begin
					f_ok = 1'b1;
					if (at_bottom) f_scroll = allow_q;
					else n_row = cursor_row_q + 6'd1;
				end
			end
			FUNC_LEFT: begin
				if (pos_valid) begin
					f_ok = 1'b1;
					if (cursor_col_q == 7'd0) begin
						n_col = 7'(cols - 8'd1);
						if (at_top) f_scroll = allow_q;
						else n_row = cursor_row_q - 6'd1;
					end else begin
						n_col = cursor_col_q - 7'd1;
					end
				end
			end
			FUNC_RIGHT: begin
				if (pos_valid) begin
					f_ok = 1'b1;
					if ({1'b0, cursor_col_q} + 8'd1 < cols) begin
						n_col = cursor_col_q + 7'd1;
					end else begin
						n_col = 7'd0;
						if (at_bottom) f_scroll = allow_q;
						else n_row = cursor_row_q + 6'd1;
					end
				end
			end
			FUNC_SET_TYPE: begin
				if (req_type_q != SHAPE_INVALID) begin
					f_shape = req_type_q;
					f_ok    = 1'b1;
				end
			end
			FUNC_TO_OFFSET: begin
				if (({1'b0, req_row_q} < rows) && ({1'b0, req_col_q} < cols)) begin
					f_offset = acc_q;
					f_ok     = 1'b1;
				end
			end
			FUNC_FROM_OFFSET: begin
				f_ok = !q_over;
			end
			default: begin
			end
		endcase
		if (func_q == FUNC_FROM_OFFSET) begin
			f_row = q_over ? 6'(rows - 7'd1) : acc_q[5:0];
			f_col = q_over ? 7'(cols - 8'd1) : rem_q;
		end else begin
			f_row = n_row;
			f_col = n_col;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q       <= ROW_COUNT_RST;
			column_count_q    <= COLUMN_COUNT_RST;
			block_last_scan_q <= BLOCK_LAST_SCAN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROW_COUNT:       row_count_q       <= cfg_data[6:0];
				REG_COLUMN_COUNT:    column_count_q    <= cfg_data;
				REG_BLOCK_LAST_SCAN: block_last_scan_q <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	// Capture the command word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q     <= func_t'(func);
			req_row_q  <= req_row;
			req_col_q  <= req_col;
			allow_q    <= allow_scroll;
			req_type_q <= req_type;
		end
	end

	// Sequencer, datapath registers, cursor state and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= 4'd0;
			acc_q          <= 13'd0;
			rem_q          <= 7'd0;
			mrow_q         <= 6'd0;
			cursor_row_q   <= 6'd0;
			cursor_col_q   <= 7'd0;
			cursor_shape_q <= SHAPE_BLOCK;
			out_valid_q    <= 1'b0;
			ok_q           <= 1'b0;
			scroll_q       <= 1'b0;
			out_row_q      <= 6'd0;
			out_col_q      <= 7'd0;
			out_offset_q   <= 13'd0;
			shape_q        <= SHAPE_BLOCK;
			last_scan_q    <= 5'd0;
		end else begin
			// drop the result word once taken, unless a new one replaces it
			if (out_valid_q && out_ready && (state_q != ST_FIN)) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q  <= 4'd0;
						rem_q  <= 7'd0;
						mrow_q <= req_row;
						acc_q  <= 13'd0;
						if (func_t'(func) == FUNC_FROM_OFFSET) begin
							acc_q   <= req_offset;
							state_q <= ST_DIV;
						end else if (func_t'(func) == FUNC_TO_OFFSET && req_in_range) begin
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_MUL: begin
					acc_q  <= alu_sum[12:0];
					mrow_q <= {mrow_q[4:0], 1'b0};
					cnt_q  <= cnt_q + 4'd1;
					if (cnt_q == MUL_LAST_STEP) state_q <= ST_FIN;
				end
				ST_DIV: begin
					acc_q <= {acc_q[11:0], div_fits};
					rem_q <= div_rem;
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == DIV_LAST_STEP) state_q <= ST_FIN;
				end
				ST_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						cursor_row_q   <= n_row;
						cursor_col_q   <= n_col;
						cursor_shape_q <= f_shape;
						out_valid_q    <= 1'b1;
						ok_q           <= f_ok;
						scroll_q       <= f_scroll;
						out_row_q      <= f_row;
						out_col_q      <= f_col;
						out_offset_q   <= f_offset;
						shape_q        <= f_shape;
						last_scan_q    <= (f_shape == SHAPE_BLOCK) ? block_last_scan_q
							: {3'd0, f_shape};
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign scroll     = scroll_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign out_offset = out_offset_q;
	assign shape      = shape_q;
	assign first_scan = 5'd0;
	assign last_scan  = last_scan_q;

	// A scroll request or an offset only comes with a successful command
	a_scroll_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scroll |-> ok)
		else $error("scroll raised on a rejected command");

	a_offset_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_offset != 13'd0) |-> ok)
		else $error("offset given on a rejected command");

	// The stored shape never takes the invalid code
	a_shape_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_shape_q != SHAPE_INVALID)
		else $error("invalid cursor shape stored");

	// The step counter stays within the division length while dividing
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q <= DIV_LAST_STEP))
		else $error("division step counter overran");

endmodule
